### hw/rtl/stack_machine_interpreter_top_assert.svh
// assertion macros for the stack machine interpreter
`ifndef STACK_MACHINE_INTERPRETER_TOP_ASSERT_SVH
`define STACK_MACHINE_INTERPRETER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SMI_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SMI_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/smi_pkg.sv
// shared types and constants for the stack machine interpreter
`timescale 1ns / 1ps

package smi_pkg;

  // storage sizes
  localparam int PROG_DEPTH  = 256;
  localparam int STACK_DEPTH = 64;
  localparam int PROG_AW     = $clog2(PROG_DEPTH);
  localparam int PC_W        = PROG_AW + 1;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int SP_W        = STACK_AW + 1;

  // field widths
  localparam int OP_W     = 3;
  localparam int DATA_W   = 32;
  localparam int STEP_W   = 20;
  localparam int STATUS_W = 3;
  localparam int INSTR_W  = OP_W + DATA_W;

  localparam logic [STEP_W-1:0] STEP_LIMIT_RST = STEP_W'(65535);

  // opcodes
  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_STORE  = 3'd1;
  localparam logic [OP_W-1:0] OP_LOAD   = 3'd2;
  localparam logic [OP_W-1:0] OP_PLUS   = 3'd3;
  localparam logic [OP_W-1:0] OP_TIMES  = 3'd4;
  localparam logic [OP_W-1:0] OP_IFZERO = 3'd5;
  localparam logic [OP_W-1:0] OP_DONE   = 3'd6;

  // completion status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LIMIT = 3'd5;

  // sequencer states
  typedef enum logic [2:0] {
    S_LOAD,
    S_FETCH,
    S_DECODE,
    S_RDB,
    S_ALU,
    S_WB,
    S_EXEC
  } state_t;

  // control for the shared arithmetic unit
  typedef struct packed {
    logic en;
    logic mul;
  } alu_ctl_t;

endpackage

### hw/rtl/smi_alu.sv
// shared add / multiply unit with registered result
`timescale 1ns / 1ps

module smi_alu
  import smi_pkg::*;
(
  input  logic              clk,
  input  alu_ctl_t          ctl,
  input  logic [DATA_W-1:0] opa,
  input  logic [DATA_W-1:0] opb,
  output logic [DATA_W-1:0] res_r
);

  logic [DATA_W-1:0] res_nxt;

  // 32-bit wrapping sum or low half of product
  always_comb begin
    if (ctl.mul) begin
      res_nxt = opa * opb;
    end else begin
      res_nxt = opa + opb;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      res_r <= res_nxt;
    end
  end

endmodule

### hw/rtl/stack_machine_interpreter_top.sv
// stack machine interpreter: program load, sequencer, stores and result port
// Loading: the word marked last starts a run.
// Run per instruction: push, load and no-op pass fetch and decode; store, ifzero and done add
// an exec state; plus and times add two stack reads, the shared add/multiply unit and write back.
// Stops: at fetch, at decode for a stack error, at exec for a bad jump target; strobe in the cycle after.
// Throughput: one item per cycle while loading, busy for the whole run; no stall on output.
// Reset (rst_n, synchronous): clears sequencer, lengths and counts, step_limit to 65535.
`timescale 1ns / 1ps

`include "stack_machine_interpreter_top_assert.svh"

module stack_machine_interpreter_top
  import smi_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  // input transactions
  input  logic                       start,
  output logic                       busy,
  input  logic [OP_W-1:0]            in_instr_op,
  input  logic signed [DATA_W-1:0]   in_instr_operand,
  input  logic                       in_last_instr,
  // configuration
  input  logic                       cfg_wr_en,
  input  logic [STEP_W-1:0]          cfg_wr_data,
  // result transactions
  output logic                       out_valid,
  output logic signed [DATA_W-1:0]   out_top_value,
  output logic [STATUS_W-1:0]        out_status,
  output logic [STEP_W-1:0]          out_steps_used
);

  state_t              state_r, state_nxt;
  logic [PC_W-1:0]     len_r, len_nxt;
  logic [PC_W-1:0]     pc_r, pc_nxt;
  logic [SP_W-1:0]     sp_r, sp_nxt;
  logic [STEP_W-1:0]   used_r, used_nxt;
  logic [DATA_W-1:0]   save_r, save_nxt;
  logic [STEP_W-1:0]   limit_r, limit_nxt;

  logic [INSTR_W-1:0]  prog_mem [PROG_DEPTH];
  logic [DATA_W-1:0]   stk_mem [STACK_DEPTH];
  logic [OP_W-1:0]     ir_op_r;
  logic [DATA_W-1:0]   ir_arg_r;
  logic [DATA_W-1:0]   stk_q_r;
  logic [DATA_W-1:0]   opa_r;
  logic [DATA_W-1:0]   alu_res;

  logic                prog_we, prog_re;
  logic                stk_we, stk_re, opa_ld;
  logic [STACK_AW-1:0] stk_waddr, stk_raddr;
  logic [DATA_W-1:0]   stk_wdata;
  logic [SP_W-1:0]     sp_m1, sp_m2;
  logic [PC_W-1:0]     pc_inc;
  logic [STEP_W-1:0]   used_inc;
  alu_ctl_t            alu_ctl;

  logic                fin;
  logic [STATUS_W-1:0] fin_status;
  logic [DATA_W-1:0]   fin_top;
  logic [STEP_W-1:0]   fin_steps;

  logic                out_valid_r;
  logic [DATA_W-1:0]   out_top_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [STEP_W-1:0]   out_steps_r;

  assign sp_m1    = sp_r - SP_W'(1);
  assign sp_m2    = sp_r - SP_W'(2);
  assign pc_inc   = pc_r + PC_W'(1);
  assign used_inc = used_r + STEP_W'(1);

  // shared arithmetic unit: a is the top entry, b the one below
  smi_alu u_alu (
    .clk   (clk),
    .ctl   (alu_ctl),
    .opa   (opa_r),
    .opb   (stk_q_r),
    .res_r (alu_res)
  );

  // sequencer next state and datapath controls
  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    pc_nxt     = pc_r;
    sp_nxt     = sp_r;
    used_nxt   = used_r;
    save_nxt   = save_r;
    limit_nxt  = cfg_wr_en ? cfg_wr_data : limit_r;
    prog_we    = 1'b0;
    prog_re    = 1'b0;
    stk_we     = 1'b0;
    stk_re     = 1'b0;
    opa_ld     = 1'b0;
    stk_waddr  = sp_r[STACK_AW-1:0];
    stk_wdata  = ir_arg_r;
    stk_raddr  = sp_m1[STACK_AW-1:0];
    alu_ctl    = '0;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_top    = '0;
    fin_steps  = used_r;

    unique case (state_r)
      S_LOAD: begin
        if (start) begin
          // words past the end of the store are dropped
          if (len_r < PC_W'(PROG_DEPTH)) begin
            prog_we = 1'b1;
            len_nxt = len_r + PC_W'(1);
          end
          if (in_last_instr) begin
            state_nxt = S_FETCH;
            pc_nxt    = '0;
            used_nxt  = '0;
          end
        end
      end
      S_FETCH: begin
        if (used_r == limit_r) begin
          fin        = 1'b1;
          fin_status = ST_LIMIT;
        end else if (pc_r >= len_r) begin
          fin        = 1'b1;
          fin_status = ST_RANGE;
        end else begin
          prog_re   = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (ir_op_r) inside
          OP_PUSH, OP_LOAD: begin
            if (sp_r >= SP_W'(STACK_DEPTH)) begin
              fin        = 1'b1;
              fin_status = ST_OVER;
            end else begin
              stk_we    = 1'b1;
              stk_wdata = (ir_op_r == OP_PUSH) ? ir_arg_r : save_r;
              sp_nxt    = sp_r + SP_W'(1);
              used_nxt  = used_inc;
              pc_nxt    = pc_inc;
              state_nxt = S_FETCH;
            end
          end
          OP_PLUS, OP_TIMES: begin
            if (sp_r < SP_W'(2)) begin
              fin        = 1'b1;
              fin_status = ST_UNDER;
            end else begin
              stk_re    = 1'b1;
              state_nxt = S_RDB;
            end
          end
          OP_STORE, OP_IFZERO: begin
            if (sp_r == '0) begin
              fin        = 1'b1;
              fin_status = ST_UNDER;
            end else begin
              stk_re    = 1'b1;
              state_nxt = S_EXEC;
            end
          end
          OP_DONE: begin
            if (sp_r == '0) begin
              fin        = 1'b1;
              fin_status = ST_EMPTY;
            end else begin
              stk_re    = 1'b1;
              state_nxt = S_EXEC;
            end
          end
          default: begin
            // undefined opcode runs as a no-op
            used_nxt  = used_inc;
            pc_nxt    = pc_inc;
            state_nxt = S_FETCH;
          end
        endcase
      end
      S_RDB: begin
        // hold the top entry, read the one below it
        opa_ld    = 1'b1;
        stk_re    = 1'b1;
        stk_raddr = sp_m2[STACK_AW-1:0];
        state_nxt = S_ALU;
      end
      S_ALU: begin
        alu_ctl.en  = 1'b1;
        alu_ctl.mul = (ir_op_r == OP_TIMES);
        state_nxt   = S_WB;
      end
      S_WB: begin
        stk_we    = 1'b1;
        stk_waddr = sp_m2[STACK_AW-1:0];
        stk_wdata = alu_res;
        sp_nxt    = sp_m1;
        used_nxt  = used_inc;
        pc_nxt    = pc_inc;
        state_nxt = S_FETCH;
      end
      S_EXEC: begin
        case (ir_op_r)
          OP_STORE: begin
            save_nxt  = stk_q_r;
            sp_nxt    = sp_m1;
            used_nxt  = used_inc;
            pc_nxt    = pc_inc;
            state_nxt = S_FETCH;
          end
          OP_IFZERO: begin
            if ((stk_q_r == '0) && (ir_arg_r >= DATA_W'(len_r))) begin
              // taken branch to a target outside the program
              fin        = 1'b1;
              fin_status = ST_RANGE;
            end else begin
              sp_nxt    = sp_m1;
              used_nxt  = used_inc;
              pc_nxt    = (stk_q_r == '0) ? ir_arg_r[PC_W-1:0] : pc_inc;
              state_nxt = S_FETCH;
            end
          end
          default: begin
            // done: report the top entry, count the done itself
            fin       = 1'b1;
            fin_top   = stk_q_r;
            fin_steps = used_inc;
          end
        endcase
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    // end of run: ready for a fresh program
    if (fin) begin
      state_nxt = S_LOAD;
      len_nxt   = '0;
      sp_nxt    = '0;
      save_nxt  = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      len_r       <= '0;
      pc_r        <= '0;
      sp_r        <= '0;
      used_r      <= '0;
      save_r      <= '0;
      limit_r     <= STEP_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      pc_r        <= pc_nxt;
      sp_r        <= sp_nxt;
      used_r      <= used_nxt;
      save_r      <= save_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= fin;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fin) begin
      out_top_r    <= fin_top;
      out_status_r <= fin_status;
      out_steps_r  <= fin_steps;
    end
  end

  // program store: written while loading, read at the program counter
  always_ff @(posedge clk) begin
    if (prog_we) begin
      prog_mem[len_r[PROG_AW-1:0]] <= {in_instr_op, in_instr_operand};
    end
    if (prog_re) begin
      {ir_op_r, ir_arg_r} <= prog_mem[pc_r[PROG_AW-1:0]];
    end
  end

  // value stack: one write and one read port
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_q_r <= stk_mem[stk_raddr];
    end
    if (opa_ld) begin
      opa_r <= stk_q_r;
    end
  end

  assign busy           = (state_r != S_LOAD);
  assign out_valid      = out_valid_r;
  assign out_top_value  = signed'(out_top_r);
  assign out_status     = out_status_r;
  assign out_steps_used = out_steps_r;

  // checks on the sequencer and result path
  `SMI_ASSERT_IMP(a_result_when_idle, out_valid_r, state_r == S_LOAD, "result outside idle")
  `SMI_ASSERT_NXT(a_single_strobe, out_valid_r, !out_valid_r, "result strobe repeated")
  `SMI_ASSERT_IMP(a_stack_bound, 1'b1, sp_r <= SP_W'(STACK_DEPTH), "stack count too large")
  `SMI_ASSERT_IMP(a_idle_stack_empty, state_r == S_LOAD, sp_r == '0, "stack left over after run")
  `SMI_ASSERT_IMP(a_error_zero_top, out_valid_r && (out_status_r != ST_OK), out_top_r == '0, "nonzero top on error")

endmodule

### tb/tb_stack_machine_interpreter_top.sv
// testbench for the stack machine interpreter: program loads, runs, step limits and results
`timescale 1ns / 1ps

module tb_stack_machine_interpreter_top;
  import smi_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 9;
  localparam int ITEM_TARGET  = 1700;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 6000000;
  // opcode seven has no meaning and runs as a no-op
  localparam logic [OP_W-1:0] OP_NOP = 3'd7;
  localparam logic [STEP_W-1:0] STEP_LIMIT_MAX = '1;
  // step limits above this only run programs without backward jumps
  localparam int LOOP_SAFE_LIMIT = 400;

  typedef struct packed {
    bit [OP_W-1:0]   code;
    bit [DATA_W-1:0] arg;
    bit              last;
  } instr_word_t;

  typedef struct packed {
    bit [DATA_W-1:0]   top;
    bit [STATUS_W-1:0] status;
    bit [STEP_W-1:0]   steps;
  } run_result_t;

  typedef enum int {KIND_REGULAR, KIND_NOISE, KIND_DEEP, KIND_FULL} prog_kind_t;

  // program image, interpreter copy and queue of pending run results
  class run_tracker;
    bit [OP_W-1:0]   code_mem [PROG_DEPTH];
    bit [DATA_W-1:0] arg_mem [PROG_DEPTH];
    int unsigned     code_len;
    bit [STEP_W-1:0] step_limit;
    run_result_t     pending_runs [$];
    int unsigned     mismatch_count;

    function new();
      code_len = 0;
      step_limit = STEP_LIMIT_RST;
      mismatch_count = 0;
    endfunction

    task report(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatch_count++;
    endtask

    function int pending();
      return pending_runs.size();
    endfunction

    // interpret the loaded program from index 0
    function run_result_t execute_program();
      bit [DATA_W-1:0] vals [STACK_DEPTH];
      bit [DATA_W-1:0] save_reg;
      bit [DATA_W-1:0] a;
      bit [DATA_W-1:0] b;
      bit [DATA_W-1:0] arg;
      bit [OP_W-1:0]   code;
      int unsigned     depth;
      int unsigned     pc;
      int unsigned     nxt;
      int unsigned     used;
      run_result_t     res;
      depth = 0;
      pc = 0;
      used = 0;
      save_reg = '0;
      res.top = '0;
      res.status = ST_OK;
      forever begin
        if (used == step_limit) begin
          res.status = ST_LIMIT;
          break;
        end
        if (pc >= code_len) begin
          res.status = ST_RANGE;
          break;
        end
        code = code_mem[pc];
        arg = arg_mem[pc];
        nxt = pc + 1;
        if (code == OP_PUSH || code == OP_LOAD) begin
          if (depth >= STACK_DEPTH) begin
            res.status = ST_OVER;
            break;
          end
          vals[depth] = (code == OP_PUSH) ? arg : save_reg;
          depth++;
        end else if (code == OP_STORE) begin
          if (depth < 1) begin
            res.status = ST_UNDER;
            break;
          end
          depth--;
          save_reg = vals[depth];
        end else if (code == OP_PLUS || code == OP_TIMES) begin
          if (depth < 2) begin
            res.status = ST_UNDER;
            break;
          end
          a = vals[depth-1];
          b = vals[depth-2];
          depth--;
          vals[depth-1] = (code == OP_PLUS) ? a + b : a * b;
        end else if (code == OP_IFZERO) begin
          if (depth < 1) begin
            res.status = ST_UNDER;
            break;
          end
          // taken jump checks the target, untaken ignores it
          if (vals[depth-1] == '0) begin
            if (arg >= code_len) begin
              res.status = ST_RANGE;
              break;
            end
            nxt = arg;
          end
          depth--;
        end else if (code == OP_DONE) begin
          if (depth < 1) begin
            res.status = ST_EMPTY;
            break;
          end
          used++;
          res.top = vals[depth-1];
          break;
        end
        used++;
        pc = nxt;
      end
      if (res.status != ST_OK) res.top = '0;
      res.steps = used[STEP_W-1:0];
      return res;
    endfunction

    // accepted input transaction; returns whether the word was stored
    function bit take_word(input instr_word_t w);
      bit stored;
      stored = (code_len < PROG_DEPTH);
      if (stored) begin
        code_mem[code_len] = w.code;
        arg_mem[code_len] = w.arg;
        code_len++;
      end
      if (w.last) begin
        pending_runs.push_back(execute_program());
        code_len = 0;
      end
      return stored;
    endfunction

    // result transaction against the oldest pending run
    task check_run(input logic [DATA_W-1:0] top, input logic [STATUS_W-1:0] status,
                   input logic [STEP_W-1:0] steps);
      run_result_t exp_run;
      if (pending_runs.size() == 0) begin
        report($sformatf("result with no run pending: top %h status %0d steps %0d",
                         top, status, steps));
      end else begin
        exp_run = pending_runs.pop_front();
        if (top !== exp_run.top)
          report($sformatf("top_value got %h, expected %h", top, exp_run.top));
        if (status !== exp_run.status)
          report($sformatf("status got %0d, expected %0d", status, exp_run.status));
        if (steps !== exp_run.steps)
          report($sformatf("steps_used got %0d, expected %0d", steps, exp_run.steps));
      end
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [OP_W-1:0]          in_instr_op = '0;
  logic signed [DATA_W-1:0] in_instr_operand = '0;
  logic                     in_last_instr = 1'b0;
  logic                     cfg_wr_en = 1'b0;
  logic [STEP_W-1:0]        cfg_wr_data = '0;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_top_value;
  logic [STATUS_W-1:0]      out_status;
  logic [STEP_W-1:0]        out_steps_used;

  run_tracker  tracker = new();
  instr_word_t prog_q [$];
  int unsigned words_stored = 0;
  int unsigned cycle_count = 0;

  stack_machine_interpreter_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_instr_op      (in_instr_op),
    .in_instr_operand (in_instr_operand),
    .in_last_instr    (in_last_instr),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_top_value    (out_top_value),
    .out_status       (out_status),
    .out_steps_used   (out_steps_used)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_run(out_top_value, out_status, out_steps_used);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      tracker.report($sformatf("timeout after %0d cycles", cycle_count));
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void add_word(input bit [OP_W-1:0] code, input bit [DATA_W-1:0] arg,
                                   input bit last);
    prog_q.push_back(instr_word_t'{code, arg, last});
  endfunction

  // operand values weighted toward zero and the extremes
  function automatic bit [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0, 1, 2: return '0;
      3: return 32'd1;
      4: return '1;
      5: return 32'h8000_0000;
      6: return 32'h7fff_ffff;
      7: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // jump target: mostly valid, forward only when loops must end on their own
  function automatic bit [DATA_W-1:0] pick_target(input int pos, input int len, input bit fwd);
    case ($urandom_range(0, 9))
      0: return $urandom | 32'h8000_0000;
      1: return len + $urandom_range(0, 3);
      2: return $urandom | 32'h0000_1000;
      default: begin
        if (!fwd) return $urandom_range(0, len - 1);
        return (pos + 1 < len) ? $urandom_range(pos + 1, len - 1) : len;
      end
    endcase
  endfunction

  function automatic int stack_delta(input bit [OP_W-1:0] code);
    if (code == OP_PUSH || code == OP_LOAD) return 1;
    if (code == OP_STORE || code == OP_PLUS || code == OP_TIMES || code == OP_IFZERO)
      return -1;
    return 0;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void build_program(input prog_kind_t kind, input bit fwd);
    int len;
    int depth;
    int r;
    bit [OP_W-1:0] code;
    bit [DATA_W-1:0] arg;
    depth = 0;
    case (kind)
      // stack-aware program ending in done
      KIND_REGULAR: begin
        len = $urandom_range(1, 24);
        for (int i = 0; i < len - 1; i++) begin
          r = $urandom_range(0, 99);
          if (depth == 0) code = (r < 75) ? OP_PUSH : OP_LOAD;
          else if (r < 30) code = OP_PUSH;
          else if (r < 40) code = OP_LOAD;
          else if (r < 52) code = OP_STORE;
          else if (r < 64) code = OP_PLUS;
          else if (r < 76) code = OP_TIMES;
          else if (r < 94) code = OP_IFZERO;
          else if (r < 97) code = OP_NOP;
          else code = OP_DONE;
          if ((code == OP_PLUS || code == OP_TIMES) && depth < 2) code = OP_PUSH;
          depth += stack_delta(code);
          arg = (code == OP_IFZERO) ? pick_target(i, len, fwd) : rand_word();
          add_word(code, arg, 1'b0);
        end
        add_word(OP_DONE, rand_word(), 1'b1);
      end
      // any opcode in any order
      KIND_NOISE: begin
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++) begin
          code = OP_W'($urandom_range(0, 7));
          arg = (code == OP_IFZERO) ? pick_target(i, len, fwd) : rand_word();
          add_word(code, arg, i == len - 1);
        end
      end
      // stack filled up to and past its depth
      KIND_DEEP: begin
        len = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 6);
        for (int i = 0; i < len; i++)
          add_word(($urandom_range(0, 3) == 0) ? OP_LOAD : OP_PUSH, rand_word(), 1'b0);
        add_word(OP_DONE, '0, 1'b1);
      end
      // program store filled, later words dropped, last one still starts the run
      KIND_FULL: begin
        len = $urandom_range(PROG_DEPTH, PROG_DEPTH + 44);
        for (int i = 0; i < len - 1; i++) begin
          r = $urandom_range(0, 99);
          if (depth == 0) code = OP_PUSH;
          else if (depth >= STACK_DEPTH - 4) code = OP_STORE;
          else if (r < 35) code = OP_PUSH;
          else if (r < 45) code = OP_LOAD;
          else if (r < 65) code = OP_STORE;
          else if (r < 80 && depth >= 2) code = OP_PLUS;
          else if (r < 90 && depth >= 2) code = OP_TIMES;
          else code = OP_NOP;
          if (i == PROG_DEPTH - 1 && r[0]) code = OP_DONE;
          depth += stack_delta(code);
          add_word(code, rand_word(), 1'b0);
        end
        add_word(OP_DONE, rand_word(), 1'b1);
      end
      default: ;
    endcase
  endfunction

  // one input transaction, start left high for a following word
  task automatic send_word(input instr_word_t w);
    start <= 1'b1;
    in_instr_op <= w.code;
    in_instr_operand <= w.arg;
    in_last_instr <= w.last;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (tracker.take_word(w)) words_stored++;
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_program(input bit burst);
    foreach (prog_q[i]) begin
      send_word(prog_q[i]);
      if (!burst) idle_gap(pick_gap());
    end
    prog_q.delete();
  endtask

  // wait for every pending run and let the block settle
  task automatic drain();
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_step_limit(input bit [STEP_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.step_limit = value;
  endtask

  initial begin
    bit [STEP_W-1:0] limit;
    int              phase;
    int              runs;
    int              r;
    prog_kind_t      kind;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed programs under the reset step limit
    // signed wrap on plus
    add_word(OP_PUSH, 32'h7fff_ffff, 1'b0);
    add_word(OP_PUSH, 32'd1, 1'b0);
    add_word(OP_PLUS, '0, 1'b0);
    add_word(OP_DONE, '0, 1'b1);
    // times wrap, store and load
    add_word(OP_PUSH, '1, 1'b0);
    add_word(OP_PUSH, 32'h8000_0000, 1'b0);
    add_word(OP_TIMES, '0, 1'b0);
    add_word(OP_STORE, '0, 1'b0);
    add_word(OP_LOAD, '0, 1'b0);
    add_word(OP_DONE, '0, 1'b1);
    // underflow on store
    add_word(OP_STORE, '0, 1'b1);
    // empty stack at done
    add_word(OP_DONE, '0, 1'b1);
    // taken jump past the program
    add_word(OP_PUSH, '0, 1'b0);
    add_word(OP_IFZERO, 32'd5, 1'b1);
    // taken jump to a negative target
    add_word(OP_PUSH, '0, 1'b0);
    add_word(OP_IFZERO, 32'h8000_0000, 1'b1);
    // untaken jump ignores its target, no-op, then run off the end
    add_word(OP_PUSH, 32'd1, 1'b0);
    add_word(OP_IFZERO, 32'hffff_fff9, 1'b0);
    add_word(OP_NOP, '0, 1'b0);
    add_word(OP_PUSH, 32'd3, 1'b1);
    // endless loop stopped by the reset step limit
    add_word(OP_PUSH, '0, 1'b0);
    add_word(OP_IFZERO, '0, 1'b1);
    send_program(1'b0);

    // zero limit stops at once, one allows a single instruction
    drain();
    write_step_limit('0);
    add_word(OP_PUSH, 32'd5, 1'b0);
    add_word(OP_DONE, '0, 1'b1);
    send_program(1'b1);
    drain();
    write_step_limit(20'd1);
    add_word(OP_PUSH, 32'd5, 1'b0);
    add_word(OP_DONE, '0, 1'b1);
    send_program(1'b0);

    // random phases, each under its own step limit
    phase = 0;
    while (words_stored < ITEM_TARGET) begin
      drain();
      if (phase == 0) limit = STEP_LIMIT_MAX;
      else begin
        case ($urandom_range(0, 9))
          0: limit = 20'd1;
          1: limit = STEP_LIMIT_MAX;
          2: limit = '0;
          default: limit = STEP_W'($urandom_range(2, LOOP_SAFE_LIMIT));
        endcase
      end
      write_step_limit(limit);
      runs = $urandom_range(4, 12);
      for (int k = 0; k < runs; k++) begin
        r = $urandom_range(0, 99);
        if (phase == 0 && k == 0) kind = KIND_FULL;
        else if (phase == 0 && k == 1) kind = KIND_DEEP;
        else if (r < 70) kind = KIND_REGULAR;
        else if (r < 92) kind = KIND_NOISE;
        else if (r < 98) kind = KIND_DEEP;
        else kind = KIND_FULL;
        build_program(kind, limit > LOOP_SAFE_LIMIT);
        send_program($urandom_range(0, 3) == 0);
      end
      phase++;
    end

    drain();
    if (tracker.mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
